@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define KLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define KLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/klp_pkg.sv @@
package klp_pkg;

  localparam int unsigned FrameCapacity = 64;
  localparam int unsigned Channels      = 6;
  localparam int unsigned ValW          = 24;
  localparam int unsigned AccW          = 32;
  localparam int unsigned StepW         = 10;
  localparam int unsigned DivBits       = 32;
  localparam int unsigned DivCntW       = $clog2(DivBits);
  localparam int unsigned ChW           = $clog2(Channels);
  localparam logic [StepW-1:0] StepsReset = StepW'(30);

  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdStop = 2'd1,
    CmdTick = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef struct packed {
    logic in_ready;
    logic do_load;
    logic do_add;
    logic set_done;
    logic seg_inc;
    logic rewind;
    logic rd_en;
    logic rd_next;
    logic cap_a;
    logic pose_from_row;
    logic clr_inc;
    logic div_load;
    logic div_step;
    logic div_store;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic take_in;
    cmd_e cmd;
    logic done;
    logic step_lt;
    logic seg_last;
    logic has_next;
    logic div_last;
    logic ch_last;
    logic out_free;
  } ctl_stat_t;

endpackage

@@ rtl/klp_if.sv @@
interface klp_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [23:0]       key_base_x;
  logic signed [23:0]       key_base_z;
  logic signed [23:0]       key_cabin_angle;
  logic signed [23:0]       key_boom_angle;
  logic signed [23:0]       key_arm_angle;
  logic signed [23:0]       key_claw_angle;
  modport source (output valid, command, key_base_x, key_base_z, key_cabin_angle,
                  key_boom_angle, key_arm_angle, key_claw_angle, input ready);
  modport sink (input valid, command, key_base_x, key_base_z, key_cabin_angle,
                key_boom_angle, key_arm_angle, key_claw_angle, output ready);
endinterface

interface klp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pose_base_x;
  logic signed [23:0] pose_base_z;
  logic signed [23:0] pose_cabin_angle;
  logic signed [23:0] pose_boom_angle;
  logic signed [23:0] pose_arm_angle;
  logic signed [23:0] pose_claw_angle;
  logic [5:0]         segment_now;
  logic               finished;
  logic [6:0]         frames_stored;
  modport source (output valid, pose_base_x, pose_base_z, pose_cabin_angle,
                  pose_boom_angle, pose_arm_angle, pose_claw_angle, segment_now,
                  finished, frames_stored, input ready);
  modport sink (input valid, pose_base_x, pose_base_z, pose_cabin_angle,
                pose_boom_angle, pose_arm_angle, pose_claw_angle, segment_now,
                finished, frames_stored, output ready);
endinterface

interface klp_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] steps_per_segment;
  modport source (output valid, steps_per_segment, input ready);
  modport sink (input valid, steps_per_segment, output ready);
endinterface

@@ rtl/keyframe_linear_player_six_channel_unit.sv @@
// Six-channel keyframe player. Command 0 appends a keyframe (ignored when the
// table is full), command 1 rewinds the pose to keyframe 0, command 2 plays one
// tick; each command returns one result carrying the pose and status after it.
// Rewind and a tick that enters a new segment recompute the six increments with
// one shared restoring divider (a load, 32 steps and a store per channel), or
// clear them when no next keyframe follows. Keyframes sit in a single-port row
// memory, one row per keyframe. steps_per_segment may be written whenever no
// command is in flight.
module keyframe_linear_player_six_channel_unit #(
  parameter int unsigned FRAME_CAPACITY = klp_pkg::FrameCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  klp_in_if.sink     in_i,
  klp_out_if.source  out_o,
  klp_cfg_if.sink    cfg_i
);

  klp_pkg::ctl_cmd_t  cmd;
  klp_pkg::ctl_stat_t stat;

  klp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  klp_dpath #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

@@ rtl/klp_ctrl.sv @@
module klp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  klp_pkg::ctl_stat_t  stat_i,
  output klp_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    Idle, Exec, RdA, CapA, DivLoad, DivRun, DivStore, Fin
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      Idle: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.take_in) state_d = Exec;
      end
      Exec: begin
        state_d = Fin;
        unique case (stat_i.cmd)
          klp_pkg::CmdLoad: cmd_o.do_load = 1'b1;
          klp_pkg::CmdStop: begin
            cmd_o.rewind = 1'b1;
            state_d      = RdA;
          end
          klp_pkg::CmdTick: begin
            if (!stat_i.done) begin
              if (stat_i.step_lt) begin
                cmd_o.do_add = 1'b1;
              end else if (stat_i.seg_last) begin
                cmd_o.set_done = 1'b1;
              end else begin
                cmd_o.seg_inc = 1'b1;
                state_d       = RdA;
              end
            end
          end
          default: state_d = Fin;
        endcase
      end
      RdA: begin
        cmd_o.rd_en = 1'b1;
        state_d     = CapA;
      end
      CapA: begin
        cmd_o.cap_a         = 1'b1;
        cmd_o.pose_from_row = (stat_i.cmd == klp_pkg::CmdStop);
        if (stat_i.has_next) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = DivLoad;
        end else begin
          cmd_o.clr_inc = 1'b1;
          state_d       = Fin;
        end
      end
      DivLoad: begin
        cmd_o.div_load = 1'b1;
        state_d        = DivRun;
      end
      DivRun: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = DivStore;
      end
      DivStore: begin
        cmd_o.div_store = 1'b1;
        state_d         = stat_i.ch_last ? Fin : DivLoad;
      end
      Fin: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/klp_dpath.sv @@
`include "assert_macros.svh"

module klp_dpath #(
  parameter int unsigned FRAME_CAPACITY = klp_pkg::FrameCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  klp_in_if.sink             in_i,
  klp_out_if.source          out_o,
  klp_cfg_if.sink            cfg_i,
  input  klp_pkg::ctl_cmd_t  cmd_i,
  output klp_pkg::ctl_stat_t stat_o
);

  localparam int unsigned NCh  = klp_pkg::Channels;
  localparam int unsigned VW   = klp_pkg::ValW;
  localparam int unsigned AW   = klp_pkg::AccW;
  localparam int unsigned SW   = klp_pkg::StepW;
  localparam int unsigned RowW = NCh * VW;
  localparam int unsigned AdW  = $clog2(FRAME_CAPACITY);
  localparam int unsigned TW   = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned CW   = TW + 1;

  logic [RowW-1:0] mem [FRAME_CAPACITY];
  logic [RowW-1:0] rdata_q, rowa_q, key_row_q;
  logic [1:0]      cmd_q;
  logic [TW-1:0]   total_q;
  logic [AdW-1:0]  seg_q;
  logic [SW-1:0]   step_q, spr_q;
  logic            done_q;
  logic [AW-1:0]   acc_q [NCh];
  logic [AW-1:0]   inc_q [NCh];
  logic [klp_pkg::ChW-1:0]     ch_q;
  logic [klp_pkg::DivCntW-1:0] dcnt_q;
  logic [AW-1:0]   dq_q;
  logic [SW-1:0]   rem_q;
  logic            neg_q;
  logic            out_valid_q;
  logic [AW-1:0]   out_acc_q [NCh];
  logic [5:0]      out_seg_q;
  logic            out_done_q;
  logic [6:0]      out_total_q;

  logic            take_in, full;
  logic [SW-1:0]   divisor;
  logic [AdW-1:0]  rd_addr;
  logic [VW-1:0]   ch_a, ch_b;
  logic [VW:0]     diff;
  logic [VW:0]     diff_abs;
  logic [SW:0]     r2;
  logic            ge;
  logic [AW-1:0]   qsat;
  logic [AW:0]     sum [NCh];

  assign take_in = in_i.valid && in_i.ready;
  assign in_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign full = (total_q == TW'(FRAME_CAPACITY));
  assign divisor = (spr_q == '0) ? SW'(1) : spr_q;
  assign rd_addr = cmd_i.rd_next ? AdW'(seg_q + AdW'(1)) : seg_q;

  assign stat_o.take_in  = take_in;
  assign stat_o.cmd      = klp_pkg::cmd_e'(cmd_q);
  assign stat_o.done     = done_q;
  assign stat_o.step_lt  = step_q < spr_q;
  assign stat_o.seg_last = (CW'(seg_q) + CW'(2)) > CW'(total_q);
  assign stat_o.has_next = (CW'(seg_q) + CW'(1)) < CW'(total_q);
  assign stat_o.div_last = (dcnt_q == klp_pkg::DivCntW'(klp_pkg::DivBits - 1));
  assign stat_o.ch_last  = (ch_q == klp_pkg::ChW'(NCh - 1));
  assign stat_o.out_free = !out_valid_q || out_o.ready;

  // divider operands: previous keyframe from the A row, next from read data
  assign ch_a     = rowa_q[ch_q*VW +: VW];
  assign ch_b     = rdata_q[ch_q*VW +: VW];
  assign diff     = {ch_b[VW-1], ch_b} - {ch_a[VW-1], ch_a};
  assign diff_abs = diff[VW] ? (VW+1)'(0 - diff) : diff;
  assign r2       = {rem_q, dq_q[AW-1]};
  assign ge       = r2 >= {1'b0, divisor};

  always_comb begin
    if (!neg_q) begin
      qsat = dq_q[AW-1] ? {1'b0, {(AW-1){1'b1}}} : dq_q;
    end else if (dq_q > {1'b1, {(AW-1){1'b0}}}) begin
      qsat = {1'b1, {(AW-1){1'b0}}};
    end else begin
      qsat = AW'(0 - dq_q);
    end
  end

  for (genvar c = 0; c < NCh; c++) begin : g_sum
    assign sum[c] = {acc_q[c][AW-1], acc_q[c]} + {inc_q[c][AW-1], inc_q[c]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && !full) mem[total_q[AdW-1:0]] <= key_row_q;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
    if (take_in) begin
      key_row_q <= {in_i.key_claw_angle, in_i.key_arm_angle, in_i.key_boom_angle,
                    in_i.key_cabin_angle, in_i.key_base_z, in_i.key_base_x};
    end
    if (cmd_i.cap_a) rowa_q <= rdata_q;
    if (cmd_i.div_load) begin
      dq_q  <= {diff_abs[VW-1:0], 8'b0};
      neg_q <= diff[VW];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[AW-2:0], ge};
      rem_q <= ge ? SW'(r2 - {1'b0, divisor}) : r2[SW-1:0];
    end
    if (cmd_i.out_load) begin
      for (int c = 0; c < NCh; c++) out_acc_q[c] <= acc_q[c];
      out_seg_q   <= 6'(seg_q);
      out_done_q  <= done_q;
      out_total_q <= 7'(total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      total_q     <= '0;
      seg_q       <= '0;
      step_q      <= '0;
      done_q      <= 1'b0;
      spr_q       <= klp_pkg::StepsReset;
      ch_q        <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NCh; c++) begin
        acc_q[c] <= '0;
        inc_q[c] <= '0;
      end
    end else begin
      if (cfg_i.valid) spr_q <= cfg_i.steps_per_segment;
      if (take_in) cmd_q <= in_i.command;
      if (cmd_i.do_load && !full) total_q <= total_q + TW'(1);
      if (cmd_i.do_add) begin
        step_q <= step_q + SW'(1);
        for (int c = 0; c < NCh; c++) begin
          // saturate on signed overflow
          if (sum[c][AW] != sum[c][AW-1]) begin
            acc_q[c] <= {sum[c][AW], {(AW-1){~sum[c][AW]}}};
          end else begin
            acc_q[c] <= sum[c][AW-1:0];
          end
        end
      end
      if (cmd_i.set_done) done_q <= 1'b1;
      if (cmd_i.seg_inc) begin
        seg_q  <= seg_q + AdW'(1);
        step_q <= '0;
      end
      if (cmd_i.rewind) begin
        seg_q  <= '0;
        step_q <= '0;
        done_q <= 1'b0;
      end
      if (cmd_i.pose_from_row) begin
        for (int c = 0; c < NCh; c++) begin
          acc_q[c] <= (total_q != '0) ? {rdata_q[c*VW +: VW], 8'b0} : '0;
        end
      end
      if (cmd_i.cap_a) ch_q <= '0;
      if (cmd_i.clr_inc) begin
        for (int c = 0; c < NCh; c++) inc_q[c] <= '0;
      end
      if (cmd_i.div_load) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + klp_pkg::DivCntW'(1);
      if (cmd_i.div_store) begin
        inc_q[ch_q] <= qsat;
        ch_q        <= ch_q + klp_pkg::ChW'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pose_base_x      = out_acc_q[0][AW-1:8];
  assign out_o.pose_base_z      = out_acc_q[1][AW-1:8];
  assign out_o.pose_cabin_angle = out_acc_q[2][AW-1:8];
  assign out_o.pose_boom_angle  = out_acc_q[3][AW-1:8];
  assign out_o.pose_arm_angle   = out_acc_q[4][AW-1:8];
  assign out_o.pose_claw_angle  = out_acc_q[5][AW-1:8];
  assign out_o.segment_now      = out_seg_q;
  assign out_o.finished         = out_done_q;
  assign out_o.frames_stored    = out_total_q;

  `KLP_ASSERT(a_out_no_overwrite, !cmd_i.out_load || !out_valid_q || out_o.ready, "result overwritten")
  `KLP_ASSERT(a_total_bound, total_q <= TW'(FRAME_CAPACITY), "frame count above capacity")
  `KLP_ASSERT_NEXT(a_add_counts, cmd_i.do_add, step_q == SW'($past(step_q) + SW'(1)), "step not counted")

endmodule
